// File: hdl/swpr_pkg.sv
package swpr_pkg;

    // Width of the phase timeout counter and of the low-time counter.
    localparam int COUNTER_BITS = 16;

    localparam int CFG_W     = 16;
    localparam int THRESH_W  = 16;
    localparam int TIMEOUT_W = 16;
    localparam int COUNT_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;

    // Common width for comparing a counter against a register value.
    localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = '1;

    // Configuration register indexes.
    localparam logic [1:0] REG_ONE_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_BIT_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_FIRST_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_EXPECTED_BYTES = 2'd3;

    // Input item kinds carried in the slave-side tuser.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_ARM    = 1'b1;

    typedef logic [COUNTER_BITS-1:0] counter_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_WAIT_HIGH = 4'b0010,
        PH_WAIT_FALL = 4'b0100,
        PH_MEASURE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [THRESH_W-1:0]  one_threshold;
        logic [TIMEOUT_W-1:0] bit_timeout;
        logic [TIMEOUT_W-1:0] first_timeout;
        logic [COUNT_W-1:0]   expected_bytes;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  data_byte;
        logic               byte_valid;
        logic               finished;
        logic               timed_out;
        logic [COUNT_W-1:0] byte_count;
    } result_t;

endpackage

// File: hdl/swpr_decoder.sv
module swpr_decoder
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             mode,
    input  logic             line_level,
    input  swpr_pkg::cfg_t   cfg,
    output swpr_pkg::result_t res
);

    swpr_pkg::phase_t                        phase_reg, phase_next;
    swpr_pkg::counter_t                      phase_cnt_reg, phase_cnt_next;
    swpr_pkg::counter_t                      low_len_reg, low_len_next;
    logic [swpr_pkg::BYTE_W-1:0]             shift_reg, shift_next;
    logic [swpr_pkg::BIT_IDX_W-1:0]          bit_idx_reg, bit_idx_next;
    logic [swpr_pkg::COUNT_W-1:0]            rx_count_reg, rx_count_next;
    logic                                    first_bit_reg, first_bit_next;

    logic [swpr_pkg::TIMEOUT_W-1:0]          limit;
    logic                                    phase_expired;
    logic                                    bit_value;
    logic [swpr_pkg::BYTE_W-1:0]             shifted;
    logic [swpr_pkg::COUNT_W-1:0]            count_inc;
    logic                                    wait_tick;

    // The first-bit timeout applies while the first bit of a reception is awaited.
    // A saturated counter counts as expired.
    assign limit = first_bit_reg ? cfg.first_timeout : cfg.bit_timeout;
    assign phase_expired =
        (swpr_pkg::CMP_W'(phase_cnt_reg) >= swpr_pkg::CMP_W'(limit)) ||
        (phase_cnt_reg == '1);
    assign bit_value =
        (swpr_pkg::CMP_W'(low_len_reg) <= swpr_pkg::CMP_W'(cfg.one_threshold));
    assign shifted   = {shift_reg[swpr_pkg::BYTE_W-2:0], bit_value};
    assign count_inc = rx_count_reg + swpr_pkg::COUNT_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        phase_cnt_next = phase_cnt_reg;
        low_len_next   = low_len_reg;
        shift_next     = shift_reg;
        bit_idx_next   = bit_idx_reg;
        rx_count_next  = rx_count_reg;
        first_bit_next = first_bit_reg;
        res            = '0;
        wait_tick      = 1'b0;

        if (mode == swpr_pkg::MODE_ARM)
        begin
            phase_cnt_next = '0;
            low_len_next   = '0;
            shift_next     = '0;
            bit_idx_next   = '0;
            rx_count_next  = '0;
            first_bit_next = 1'b1;
            if (cfg.expected_bytes == '0)
            begin
                phase_next   = swpr_pkg::PH_IDLE;
                res.valid    = 1'b1;
                res.finished = 1'b1;
            end
            else
            begin
                phase_next = swpr_pkg::PH_WAIT_HIGH;
            end
        end
        else
        begin
            case (phase_reg)
                swpr_pkg::PH_IDLE:
                begin
                    wait_tick = 1'b0;
                end
                swpr_pkg::PH_WAIT_HIGH:
                begin
                    if (line_level)
                    begin
                        phase_next     = swpr_pkg::PH_WAIT_FALL;
                        phase_cnt_next = '0;
                    end
                    else
                    begin
                        wait_tick = 1'b1;
                    end
                end
                swpr_pkg::PH_WAIT_FALL:
                begin
                    if (!line_level)
                    begin
                        phase_next     = swpr_pkg::PH_MEASURE;
                        phase_cnt_next = '0;
                        low_len_next   = swpr_pkg::COUNTER_BITS'(1);
                    end
                    else
                    begin
                        wait_tick = 1'b1;
                    end
                end
                swpr_pkg::PH_MEASURE:
                begin
                    if (line_level)
                    begin
                        // Rising edge: the low time decides the bit.
                        first_bit_next = 1'b0;
                        phase_cnt_next = '0;
                        low_len_next   = '0;
                        if (bit_idx_reg == swpr_pkg::LAST_BIT_IDX)
                        begin
                            bit_idx_next   = '0;
                            shift_next     = '0;
                            rx_count_next  = count_inc;
                            res.valid      = 1'b1;
                            res.data_byte  = shifted;
                            res.byte_valid = 1'b1;
                            res.byte_count = count_inc;
                            res.finished   = (count_inc == cfg.expected_bytes);
                            phase_next     = (count_inc == cfg.expected_bytes) ?
                                             swpr_pkg::PH_IDLE : swpr_pkg::PH_WAIT_HIGH;
                        end
                        else
                        begin
                            shift_next   = shifted;
                            bit_idx_next = bit_idx_reg + swpr_pkg::BIT_IDX_W'(1);
                            phase_next   = swpr_pkg::PH_WAIT_HIGH;
                        end
                    end
                    else
                    begin
                        if (low_len_reg != '1)
                        begin
                            low_len_next = low_len_reg + swpr_pkg::COUNTER_BITS'(1);
                        end
                        wait_tick = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = swpr_pkg::PH_IDLE;
                end
            endcase

            if (wait_tick)
            begin
                if (phase_expired)
                begin
                    // Timeout ends the reception and drops the partial byte.
                    phase_next     = swpr_pkg::PH_IDLE;
                    phase_cnt_next = '0;
                    low_len_next   = '0;
                    shift_next     = '0;
                    bit_idx_next   = '0;
                    res.valid      = 1'b1;
                    res.finished   = 1'b1;
                    res.timed_out  = 1'b1;
                    res.byte_count = rx_count_reg;
                end
                else
                begin
                    phase_cnt_next = phase_cnt_reg + swpr_pkg::COUNTER_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= swpr_pkg::PH_IDLE;
            phase_cnt_reg <= '0;
            low_len_reg   <= '0;
            shift_reg     <= '0;
            bit_idx_reg   <= '0;
            rx_count_reg  <= '0;
            first_bit_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            low_len_reg   <= low_len_next;
            shift_reg     <= shift_next;
            bit_idx_reg   <= bit_idx_next;
            rx_count_reg  <= rx_count_next;
            first_bit_reg <= first_bit_next;
        end
    end

endmodule

// File: hdl/single_wire_pulse_width_receiver.sv
// Channel   Direction  Payload
// s_*       in         tuser: mode; tdata: line_level in bit 0, bits 7:1 zero
// m_*       out        tdata: data_byte, byte_count; tuser: byte_valid, timed_out;
//                      tlast: finished
// cfg_*     in         register write: index, data (no read-back)
//
// One input transfer is taken per clock when the output side keeps up.
// A transfer is held in the input register; its result, if any, is loaded
// into the output register when the decoder steps on that transfer.
// Reset clears the receiver to idle and loads the register reset values.
// A stalled output holds its result; the input register then fills and
// s_tready drops until the result is taken.
module single_wire_pulse_width_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] line_level, [7:1] zero
    input  logic        s_tuser,    // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [15:8] byte_count
    output logic        m_tlast,    // finished
    output logic [1:0]  m_tuser,    // [0] byte_valid, [1] timed_out

    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [swpr_pkg::CFG_W-1:0]  cfg_wdata
);

    swpr_pkg::cfg_t    cfg_reg;
    swpr_pkg::result_t res;
    swpr_pkg::result_t out_reg;

    logic in_valid_reg;
    logic in_mode_reg;
    logic in_line_reg;
    logic slot_free;
    logic advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_threshold  <= swpr_pkg::THRESH_W'(2);
            cfg_reg.bit_timeout    <= swpr_pkg::TIMEOUT_W'(7);
            cfg_reg.first_timeout  <= swpr_pkg::TIMEOUT_W'(100);
            cfg_reg.expected_bytes <= swpr_pkg::COUNT_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swpr_pkg::REG_ONE_THRESHOLD:
                    cfg_reg.one_threshold <= cfg_wdata[swpr_pkg::THRESH_W-1:0];
                swpr_pkg::REG_BIT_TIMEOUT:
                    cfg_reg.bit_timeout <= cfg_wdata[swpr_pkg::TIMEOUT_W-1:0];
                swpr_pkg::REG_FIRST_TIMEOUT:
                    cfg_reg.first_timeout <= cfg_wdata[swpr_pkg::TIMEOUT_W-1:0];
                swpr_pkg::REG_EXPECTED_BYTES:
                    cfg_reg.expected_bytes <= cfg_wdata[swpr_pkg::COUNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The held sample is processed once the output register can take
    // whatever result it produces.
    assign slot_free = !out_reg.valid || m_tready;
    assign advance   = in_valid_reg && slot_free;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_line_reg <= s_tdata[0];
        end
    end

    swpr_decoder u_decoder
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .mode       (in_mode_reg),
        .line_level (in_line_reg),
        .cfg        (cfg_reg),
        .res        (res)
    );

    // Output register: loads a result when one is produced, otherwise
    // empties once the current one has been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            if (slot_free)
            begin
                out_reg.valid <= advance && res.valid;
            end
            if (advance && res.valid)
            begin
                out_reg.data_byte  <= res.data_byte;
                out_reg.byte_valid <= res.byte_valid;
                out_reg.finished   <= res.finished;
                out_reg.timed_out  <= res.timed_out;
                out_reg.byte_count <= res.byte_count;
            end
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {out_reg.byte_count, out_reg.data_byte};
    assign m_tlast  = out_reg.finished;
    assign m_tuser  = {out_reg.timed_out, out_reg.byte_valid};

endmodule
